// ===== hdl/box_filter_3x3_rgb_assert.svh =====
// Assertion macros shared by the checker of the 3x3 box filter.
// No dependencies; included by bf3rgb_checker.sv.
`ifndef BOX_FILTER_3X3_RGB_ASSERT_SVH
`define BOX_FILTER_3X3_RGB_ASSERT_SVH

// same-cycle implication
`define BF3RGB_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bf3rgb: same-cycle check failed");

// next-cycle implication
`define BF3RGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bf3rgb: next-cycle check failed");

`endif

// ===== hdl/bf3rgb_pkg.sv =====
// Constants, codes and stage types of the 3x3 box filter.
// No dependencies; used by all files but bf3rgb_ram and the assertion header.
package bf3rgb_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 4096;

   localparam int NUM_CH = 3;
   localparam int CH_W   = 16;
   localparam int PIX_W  = NUM_CH * CH_W;

   // channel slots inside a packed pixel
   localparam int CH_RED   = 2;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 0;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int EW_W   = $clog2(MAX_WIDTH + 1);
   localparam int EH_W   = $clog2(MAX_HEIGHT + 1);
   localparam int PEND_W = $clog2(MAX_WIDTH + 2);

   localparam int WREG_W    = 12;
   localparam int HREG_W    = 13;
   localparam int CSR_W     = 13;
   localparam int CSR_IDX_W = 1;

   localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(640);
   localparam logic [HREG_W-1:0] HEIGHT_RESET = HREG_W'(480);

   // column sum of three rows per channel, full sum of nine plus rounding
   localparam int CS_W  = CH_W + 2;
   localparam int SUM_W = CH_W + 4;

   // divide by nine: q = (x * RECIP) >> RECIP_SHIFT, exact for x < 2**SUM_W
   localparam int RECIP_SHIFT = SUM_W + 3;
   localparam int RECIP_W     = SUM_W;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SHIFT + 8) / 9);
   localparam logic [SUM_W-1:0]   ROUND = SUM_W'(4);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_PIXEL = 1'b0,
      KIND_FLUSH = 1'b1
   } kind_type;

   typedef logic [NUM_CH-1:0][CH_W-1:0] pix_type;
   typedef logic [NUM_CH-1:0][CS_W-1:0] colsum_type;

   // word leaving the position counters, held while its line-buffer read is out
   typedef struct packed {
      logic             valid;
      logic             shift;
      logic             emit;
      logic             inner;
      logic             last;
      logic             too_small;
      logic [COL_W-1:0] col;
      pix_type          px;
   } s1_item_type;

   // word entering the averaging pipe
   typedef struct packed {
      logic       valid;
      logic       inner;
      logic       last;
      logic       too_small;
      pix_type    pix;
      colsum_type sum_a;
      colsum_type sum_b;
      colsum_type sum_c;
   } s2_item_type;

endpackage

// ===== hdl/bf3rgb_if.sv =====
// Request and response channel interfaces of the 3x3 box filter.
// Depends on bf3rgb_pkg.
interface bf3rgb_req_if;
   import bf3rgb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic                  kind;
   logic [CH_W-1:0]       red;
   logic [CH_W-1:0]       green;
   logic [CH_W-1:0]       blue;

   modport source (output valid, kind, red, green, blue, input ready);
   modport sink   (input valid, kind, red, green, blue, output ready);
endinterface

interface bf3rgb_rsp_if;
   import bf3rgb_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CH_W-1:0]       out_red;
   logic [CH_W-1:0]       out_green;
   logic [CH_W-1:0]       out_blue;
   logic                  last_of_frame;
   logic                  too_small;

   modport source (output valid, out_red, out_green, out_blue, last_of_frame, too_small,
                   input ready);
   modport sink   (input valid, out_red, out_green, out_blue, last_of_frame, too_small,
                   output ready);
endinterface

// ===== hdl/bf3rgb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bf3rgb_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// ===== hdl/bf3rgb_ctrl.sv =====
// Size registers and frame position counters of the 3x3 box filter.
// Depends on bf3rgb_pkg.
module bf3rgb_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [bf3rgb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bf3rgb_pkg::CSR_W-1:0]      csr_wdata,
   input  logic                              accept,
   input  logic                              kind,
   input  bf3rgb_pkg::pix_type               px,
   output bf3rgb_pkg::s1_item_type           item
);
   import bf3rgb_pkg::*;

   logic [WREG_W-1:0] width_ff, width_in;
   logic [HREG_W-1:0] height_ff, height_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PEND_W-1:0] pend_ff, pend_in;

   logic [EW_W-1:0]   eff_w;
   logic [EH_W-1:0]   eff_h;
   logic              frame_small;
   logic              at_last;
   logic              row_end;
   logic [PEND_W-1:0] pend_cap;
   logic [PEND_W-1:0] flush_k;
   logic [COL_W-1:0]  flush_col;

   // sizes as used: clamped to 1..max
   always_comb begin
      if (width_ff == '0) begin
         eff_w = EW_W'(1);
      end else if (32'(width_ff) > 32'(MAX_WIDTH)) begin
         eff_w = EW_W'(MAX_WIDTH);
      end else begin
         eff_w = EW_W'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = EH_W'(1);
      end else if (32'(height_ff) > 32'(MAX_HEIGHT)) begin
         eff_h = EH_W'(MAX_HEIGHT);
      end else begin
         eff_h = EH_W'(height_ff);
      end
   end

   assign frame_small = (eff_w < EW_W'(3)) || (eff_h < EH_W'(3));
   assign row_end     = (32'(col_ff) + 32'd1) >= 32'(eff_w);
   assign at_last     = ((32'(row_ff) + 32'd1) >= 32'(eff_h)) && row_end;

   // flush: column of the next drained pixel
   assign pend_cap  = (32'(pend_ff) > (32'(eff_w) + 32'd1)) ?
                      PEND_W'(32'(eff_w) + 32'd1) : pend_ff;
   assign flush_k   = PEND_W'(32'(eff_w) + 32'd1 - 32'(pend_cap));
   assign flush_col = (32'(flush_k) < 32'(eff_w)) ? COL_W'(flush_k) : '0;

   always_comb begin
      item      = '0;
      col_in    = col_ff;
      row_in    = row_ff;
      pend_in   = pend_ff;
      width_in  = width_ff;
      height_in = height_ff;

      if (kind_type'(kind) == KIND_PIXEL) begin
         item.valid     = 1'b1;
         item.shift     = !frame_small;
         item.emit      = frame_small || (row_ff >= ROW_W'(2)) ||
                          ((row_ff == ROW_W'(1)) && (col_ff >= COL_W'(1)));
         // output position is (row-1, col-1); never interior when col is 0
         item.inner     = !frame_small && (col_ff >= COL_W'(2)) && (row_ff >= ROW_W'(2)) &&
                          ((32'(row_ff) + 32'd1) <= 32'(eff_h)) &&
                          ((32'(col_ff) + 32'd1) <= 32'(eff_w));
         item.last      = frame_small && at_last;
         item.too_small = frame_small;
         item.col       = col_ff;
         item.px        = px;
      end else if (pend_ff != '0) begin
         item.valid     = 1'b1;
         item.shift     = 1'b1;
         item.emit      = 1'b1;
         item.last      = (pend_cap == PEND_W'(1));
         item.col       = flush_col;
         item.px        = '0;
      end

      if (accept) begin
         if (kind_type'(kind) == KIND_PIXEL) begin
            pend_in = '0;
            if (at_last) begin
               col_in = '0;
               row_in = '0;
               if (!frame_small) begin
                  pend_in = PEND_W'(32'(eff_w) + 32'd1);
               end
            end else if (row_end) begin
               col_in = '0;
               row_in = ROW_W'(32'(row_ff) + 32'd1);
            end else begin
               col_in = COL_W'(32'(col_ff) + 32'd1);
            end
         end else if (pend_ff != '0) begin
            pend_in = PEND_W'(32'(pend_cap) - 32'd1);
         end
      end

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_in  = csr_wdata[WREG_W-1:0];
            CSR_IMAGE_HEIGHT: height_in = csr_wdata[HREG_W-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         pend_ff   <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         pend_ff   <= pend_in;
      end
   end
endmodule

// ===== hdl/bf3rgb_window.sv =====
// Line buffers, read-modify-write with forwarding, and the sliding 3x3 window.
// Depends on bf3rgb_pkg and bf3rgb_ram.
module bf3rgb_window (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  bf3rgb_pkg::s1_item_type item,
   output logic                    req_ready,
   output bf3rgb_pkg::s2_item_type s2_item,
   input  logic                    s2_free
);
   import bf3rgb_pkg::*;

   s1_item_type      s1_ff, s1_in;
   logic             s1_go;
   logic             s1_wr;
   logic             rd_en;

   pix_type          upper_rd, middle_rd;
   pix_type          top_px, mid_px;
   colsum_type       new_cs;

   // window kept as center-to-be and two column sums
   pix_type          mid_ff;
   colsum_type       cs_a_ff, cs_b_ff;

   // last line-buffer write, covers a read at the edge of that write
   logic             fwd_valid_ff;
   logic [COL_W-1:0] fwd_col_ff;
   pix_type          fwd_upper_ff, fwd_middle_ff;

   assign rd_en = accept && item.valid && item.shift;

   bf3rgb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
      .clock (clock),
      .we    (s1_wr),
      .waddr (s1_ff.col),
      .wdata (mid_px),
      .re    (rd_en),
      .raddr (item.col),
      .rdata (upper_rd)
   );

   bf3rgb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
      .clock (clock),
      .we    (s1_wr),
      .waddr (s1_ff.col),
      .wdata (s1_ff.px),
      .re    (rd_en),
      .raddr (item.col),
      .rdata (middle_rd)
   );

   assign s1_go     = s1_ff.valid && (!s1_ff.emit || s2_free);
   assign s1_wr     = s1_go && s1_ff.shift;
   assign req_ready = !s1_ff.valid || s1_go;

   always_comb begin
      if (fwd_valid_ff && (fwd_col_ff == s1_ff.col)) begin
         top_px = fwd_upper_ff;
         mid_px = fwd_middle_ff;
      end else begin
         top_px = upper_rd;
         mid_px = middle_rd;
      end
      for (int ch = 0; ch < NUM_CH; ch++) begin
         new_cs[ch] = CS_W'(top_px[ch]) + CS_W'(mid_px[ch]) + CS_W'(s1_ff.px[ch]);
      end
   end

   always_comb begin
      s1_in = s1_ff;
      if (accept) begin
         s1_in = item;
      end else if (s1_go) begin
         s1_in.valid = 1'b0;
      end
   end

   always_comb begin
      s2_item.valid     = s1_go && s1_ff.emit;
      s2_item.inner     = s1_ff.inner;
      s2_item.last      = s1_ff.last;
      s2_item.too_small = s1_ff.too_small;
      s2_item.pix       = s1_ff.shift ? mid_ff : s1_ff.px;
      s2_item.sum_a     = cs_a_ff;
      s2_item.sum_b     = cs_b_ff;
      s2_item.sum_c     = new_cs;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff        <= '0;
         fwd_valid_ff <= 1'b0;
         mid_ff       <= '0;
         cs_a_ff      <= '0;
         cs_b_ff      <= '0;
      end else begin
         s1_ff <= s1_in;
         if (s1_wr) begin
            fwd_valid_ff <= 1'b1;
            mid_ff       <= mid_px;
            cs_a_ff      <= cs_b_ff;
            cs_b_ff      <= new_cs;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_wr) begin
         fwd_col_ff    <= s1_ff.col;
         fwd_upper_ff  <= mid_px;
         fwd_middle_ff <= s1_ff.px;
      end
   end
endmodule

// ===== hdl/bf3rgb_mean.sv =====
// Nine-pixel sum, divide by nine with rounding, and the response register.
// Depends on bf3rgb_pkg and the response interface.
module bf3rgb_mean (
   input  logic                    clock,
   input  logic                    reset,
   input  bf3rgb_pkg::s2_item_type s2_item,
   output logic                    s2_free,
   bf3rgb_rsp_if.source            rsp_chan
);
   import bf3rgb_pkg::*;

   typedef struct packed {
      logic                           valid;
      logic                           inner;
      logic                           last;
      logic                           too_small;
      pix_type                        pix;
      logic [NUM_CH-1:0][SUM_W-1:0]   sum;
   } s3_item_type;

   s2_item_type  s2_ff, s2_in;
   s3_item_type  s3_ff, s3_in;
   logic         s2_go, s3_go, s3_free, out_free;

   logic [NUM_CH-1:0][SUM_W+RECIP_W-1:0] prod;
   pix_type      quot;
   pix_type      out_sel;

   logic         rsp_valid_ff, rsp_valid_in;
   pix_type      out_pix_ff;
   logic         out_last_ff;
   logic         out_small_ff;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s3_go    = s3_ff.valid && out_free;
   assign s3_free  = !s3_ff.valid || s3_go;
   assign s2_go    = s2_ff.valid && s3_free;
   assign s2_free  = !s2_ff.valid || s2_go;

   assign s2_in = s2_free ? s2_item : s2_ff;

   always_comb begin
      s3_in = s3_ff;
      if (s3_free) begin
         s3_in.valid     = s2_go;
         s3_in.inner     = s2_ff.inner;
         s3_in.last      = s2_ff.last;
         s3_in.too_small = s2_ff.too_small;
         s3_in.pix       = s2_ff.pix;
         for (int ch = 0; ch < NUM_CH; ch++) begin
            s3_in.sum[ch] = SUM_W'(s2_ff.sum_a[ch]) + SUM_W'(s2_ff.sum_b[ch]) +
                            SUM_W'(s2_ff.sum_c[ch]) + ROUND;
         end
      end
   end

   // reciprocal multiply, one per channel
   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         prod[ch] = (SUM_W + RECIP_W)'(s3_ff.sum[ch]) * (SUM_W + RECIP_W)'(RECIP);
         quot[ch] = CH_W'(prod[ch] >> RECIP_SHIFT);
      end
      out_sel = s3_ff.inner ? quot : s3_ff.pix;
   end

   assign rsp_valid_in = out_free ? s3_go : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff        <= '0;
         s3_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_go) begin
         out_pix_ff   <= out_sel;
         out_last_ff  <= s3_ff.last;
         out_small_ff <= s3_ff.too_small;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_red       = out_pix_ff[CH_RED];
   assign rsp_chan.out_green     = out_pix_ff[CH_GREEN];
   assign rsp_chan.out_blue      = out_pix_ff[CH_BLUE];
   assign rsp_chan.last_of_frame = out_last_ff;
   assign rsp_chan.too_small     = out_small_ff;
endmodule

// ===== hdl/box_filter_3x3_rgb.sv =====
// Streaming 3x3 box filter over RGB frames, top level. Throughput one word per clock
// while the response is taken. A result passes the window, column-sum, nine-sum and
// response registers; in frame terms results trail input by one row plus one pixel
// (flush words drain them). The per-word line-buffer read at accept and write as the
// word moves on set the rate. Reset (synchronous): sizes 640x480, counters, window
// and pipe cleared; line buffers are not cleared and need no clearing pass.
module box_filter_3x3_rgb (
   input  logic                              clock,
   input  logic                              reset,
   bf3rgb_req_if.sink                        req_chan,
   bf3rgb_rsp_if.source                      rsp_chan,
   input  logic                              csr_we,
   input  logic [bf3rgb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bf3rgb_pkg::CSR_W-1:0]      csr_wdata
);
   import bf3rgb_pkg::*;

   logic        accept;
   logic        req_ready;
   pix_type     req_px;
   s1_item_type s0_item;
   s2_item_type s2_item;
   logic        s2_free;

   // Accept stage: a word is taken whenever the window stage is empty or moving on.
   // The response register sits at the far end, so words keep flowing into free
   // pipe slots while a result waits to be taken.
   assign accept         = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   assign req_px[CH_RED]   = req_chan.red;
   assign req_px[CH_GREEN] = req_chan.green;
   assign req_px[CH_BLUE]  = req_chan.blue;

   // Position counters and size registers. Decides per word whether it shifts the
   // window, whether it yields a result, and whether that result is an interior mean.
   // A flush word with nothing pending is taken and dropped here.
   bf3rgb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .kind      (req_chan.kind),
      .px        (req_px),
      .item      (s0_item)
   );

   // Line buffers: the read goes out on the accept edge, data returns next clock,
   // and upper <= middle, middle <= pixel is written back as the word moves on.
   // A write-forward register covers a read landing on the same edge as a write
   // to the same column (e.g. a flush at column 0 followed by a new frame).
   bf3rgb_window u_window (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item      (s0_item),
      .req_ready (req_ready),
      .s2_item   (s2_item),
      .s2_free   (s2_free)
   );

   // Sum of three column sums plus rounding, then multiply by the reciprocal of
   // nine, then the response register. Border and too-small words pass unchanged.
   bf3rgb_mean u_mean (
      .clock    (clock),
      .reset    (reset),
      .s2_item  (s2_item),
      .s2_free  (s2_free),
      .rsp_chan (rsp_chan)
   );
endmodule

// ===== hdl/bf3rgb_checker.sv =====
// Port-level checker for the 3x3 box filter, bound to the top level.
// Depends on bf3rgb_pkg and box_filter_3x3_rgb_assert.svh.
`include "box_filter_3x3_rgb_assert.svh"

module bf3rgb_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bf3rgb_pkg::CH_W-1:0] out_red,
   input logic [bf3rgb_pkg::CH_W-1:0] out_green,
   input logic [bf3rgb_pkg::CH_W-1:0] out_blue,
   input logic                        last_of_frame,
   input logic                        too_small
);
   import bf3rgb_pkg::*;

   // stalled response word holds
   `BF3RGB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(last_of_frame) && $stable(too_small))

   // input only backs up when the whole pipe is full behind a stalled response
   `BF3RGB_ASSERT_IMPLY(a_ready_backpressure, clock, reset, !req_ready, rsp_valid && !rsp_ready)

   // reset leaves the block empty and ready
   `BF3RGB_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid && req_ready)
endmodule

bind box_filter_3x3_rgb bf3rgb_checker u_bf3rgb_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .out_red       (rsp_chan.out_red),
   .out_green     (rsp_chan.out_green),
   .out_blue      (rsp_chan.out_blue),
   .last_of_frame (rsp_chan.last_of_frame),
   .too_small     (rsp_chan.too_small)
);
